/* sv/neighbour_list_bitmap_encoder_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the neighbour list bitmap encoder.
// Concurrent checks that compile away when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef NEIGHBOUR_LIST_BITMAP_ENCODER_ASSERT_SVH
`define NEIGHBOUR_LIST_BITMAP_ENCODER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Implication that must hold at every rising clock edge outside reset.
`define NLBE_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true outside reset.
`define NLBE_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define NLBE_ASSERT(lbl, clk, rst_n, prop, msg)
`define NLBE_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

/* sv/nlbe_pkg.sv */
// ----------------------------------------------------------------------------
// nlbe_pkg
// Shared constants, state codes and control types of the bitmap encoder.
// ----------------------------------------------------------------------------
package nlbe_pkg;

	localparam int NEIGHBOUR_COUNT_DEF = 16;
	localparam int MAX_ROW_BYTES_DEF   = 64;
	localparam int INDEX_WIDTH_DEF     = 32;

	localparam int BITS_PER_BYTE = 8;
	localparam int PORT_INDEX_W  = 32;
	localparam int ROW_BYTES_W   = 7;
	localparam int BYTE_POS_W    = 6;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_SPAN  = 7'b0000010,
		ST_CLEAR = 7'b0000100,
		ST_RD    = 7'b0001000,
		ST_SUB   = 7'b0010000,
		ST_WR    = 7'b0100000,
		ST_EMIT  = 7'b1000000
	} nlbe_state_t;

	// Requests from the sequencer to the index store.
	typedef struct packed {
		logic load;
		logic clear;
		logic rd_en;
	} nlbe_store_ctrl_t;

endpackage

/* sv/nlbe_index_store.sv */
// ----------------------------------------------------------------------------
// nlbe_index_store
// Neighbour index buffer with entry count, running minimum and maximum.
// ----------------------------------------------------------------------------
module nlbe_index_store #(
	parameter int NEIGHBOUR_COUNT = nlbe_pkg::NEIGHBOUR_COUNT_DEF,
	parameter int INDEX_WIDTH     = nlbe_pkg::INDEX_WIDTH_DEF,
	localparam int AW = (NEIGHBOUR_COUNT > 1) ? $clog2(NEIGHBOUR_COUNT) : 1,
	localparam int CW = $clog2(NEIGHBOUR_COUNT + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  nlbe_pkg::nlbe_store_ctrl_t ctrl,
	input  logic [INDEX_WIDTH-1:0]     wr_index,
	input  logic [AW-1:0]              rd_addr,
	output logic [INDEX_WIDTH-1:0]     rd_data,
	output logic [CW-1:0]              count,
	output logic [INDEX_WIDTH-1:0]     min_index,
	output logic [INDEX_WIDTH-1:0]     max_index,
	output logic                       dropped
);
	import nlbe_pkg::*;

	logic [INDEX_WIDTH-1:0] buf_mem [NEIGHBOUR_COUNT];
	logic [INDEX_WIDTH-1:0] rd_data_q;
	logic [CW-1:0]          count_q;
	logic [INDEX_WIDTH-1:0] min_q;
	logic [INDEX_WIDTH-1:0] max_q;
	logic                   dropped_q;
	logic                   has_room;

	assign has_room = (count_q < CW'(NEIGHBOUR_COUNT));

	always_ff @(posedge clk) begin
		if (ctrl.load && has_room) begin
			buf_mem[count_q[AW-1:0]] <= wr_index;
		end
		if (ctrl.rd_en) begin
			rd_data_q <= buf_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			min_q     <= '1;
			max_q     <= '0;
			dropped_q <= 1'b0;
		end else if (ctrl.clear) begin
			count_q   <= '0;
			min_q     <= '1;
			max_q     <= '0;
			dropped_q <= 1'b0;
		end else if (ctrl.load) begin
			if (has_room) begin
				count_q <= count_q + CW'(1);
				if (wr_index < min_q) begin
					min_q <= wr_index;
				end
				if (wr_index > max_q) begin
					max_q <= wr_index;
				end
			end else begin
				dropped_q <= 1'b1;
			end
		end
	end

	assign rd_data   = rd_data_q;
	assign count     = count_q;
	assign min_index = min_q;
	assign max_index = max_q;
	assign dropped   = dropped_q;

endmodule

/* sv/neighbour_list_bitmap_encoder.sv */
// ----------------------------------------------------------------------------
// neighbour_list_bitmap_encoder
// Encodes one point's neighbour list as a bitmap relative to its minimum.
// ----------------------------------------------------------------------------
// Usage: a request is taken on a rising edge with start high and busy low; it
// carries one neighbour_index and last_neighbour. Unmarked requests only store
// their index and produce nothing. The marked request closes the row: busy
// rises and the block computes the span, clears the bitmap store, folds every
// stored index that falls within the row into it, then emits one result per byte.
// Results appear with result_strobe high for exactly one cycle each, one per
// cycle, in byte order; row_end marks the last byte. The receiver cannot hold
// results off, so there is no stall path.
// Steps after the marked request: the span step, the clear of every row byte,
// the fold of every stored entry (buffer read, subtract, bitmap
// read-modify-write through the single shared subtractor), then the emit of
// every row byte. Each result is registered and shows in the cycle after its
// emit step, and the next request can be taken once the last emit step has
// returned the sequencer to idle.
// Reset (arst_n low) empties the index buffer count, restores the minimum to
// all ones and the maximum to zero, and returns the sequencer to idle. The
// bitmap store needs no reset since every row clears the bytes it uses.
// ----------------------------------------------------------------------------
`include "neighbour_list_bitmap_encoder_assert.svh"

module neighbour_list_bitmap_encoder #(
	parameter int NEIGHBOUR_COUNT = nlbe_pkg::NEIGHBOUR_COUNT_DEF,
	parameter int MAX_ROW_BYTES   = nlbe_pkg::MAX_ROW_BYTES_DEF,
	parameter int INDEX_WIDTH     = nlbe_pkg::INDEX_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [nlbe_pkg::PORT_INDEX_W-1:0]  neighbour_index,
	input  logic                               last_neighbour,
	output logic                               result_strobe,
	output logic [nlbe_pkg::PORT_INDEX_W-1:0]  row_offset,
	output logic [nlbe_pkg::ROW_BYTES_W-1:0]   row_length,
	output logic [nlbe_pkg::BYTE_POS_W-1:0]    byte_position,
	output logic [nlbe_pkg::BITS_PER_BYTE-1:0] bitmap_byte,
	output logic                               row_end,
	output logic                               overflow
);
	import nlbe_pkg::*;

	// Indices are masked to the narrower of the port and the configured width.
	localparam int EW = (INDEX_WIDTH < PORT_INDEX_W) ? INDEX_WIDTH : PORT_INDEX_W;
	localparam int AW = (NEIGHBOUR_COUNT > 1) ? $clog2(NEIGHBOUR_COUNT) : 1;
	localparam int CW = $clog2(NEIGHBOUR_COUNT + 1);
	localparam int BW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
	localparam int SW = $clog2(BITS_PER_BYTE);

	nlbe_state_t state_q;

	nlbe_store_ctrl_t store_ctrl;
	logic [EW-1:0]    buf_rdata;
	logic [CW-1:0]    entry_count;
	logic [EW-1:0]    run_min;
	logic [EW-1:0]    run_max;
	logic             dropped;

	logic             accept;
	logic             row_last;

	// Shared subtractor: the span in the span step, each offset in the fold.
	logic [EW-1:0]    sub_a;
	logic [EW-1:0]    diff;
	logic [EW-1:0]    diff_byte;
	logic             span_cap;

	logic [CW-1:0]            ent_q;
	logic [BW-1:0]            pos_q;
	logic [ROW_BYTES_W-1:0]   nbytes_q;
	logic                     ovf_q;
	logic [PORT_INDEX_W-1:0]  offset_q;
	logic                     hit_q;
	logic [BW-1:0]            waddr_q;
	logic [SW-1:0]            bit_q;
	logic                     pos_last;
	logic                     ent_last;

	// Bitmap store, one byte per row position.
	logic [BITS_PER_BYTE-1:0] bm_mem [MAX_ROW_BYTES];
	logic [BITS_PER_BYTE-1:0] bm_rdata_q;
	logic                     bm_we;
	logic [BW-1:0]            bm_waddr;
	logic [BITS_PER_BYTE-1:0] bm_wdata;
	logic                     bm_re;
	logic [BW-1:0]            bm_raddr;

	// Output stage.
	logic          emit_s1;
	logic          end_s1;
	logic [BW-1:0] pos_s1;

	assign accept   = start && (state_q == ST_IDLE);
	assign busy     = (state_q != ST_IDLE);
	assign pos_last = (ROW_BYTES_W'(pos_q) == nbytes_q - ROW_BYTES_W'(1));
	assign ent_last = (ent_q == entry_count - CW'(1));
	assign row_last = (state_q == ST_EMIT) && pos_last;

	assign store_ctrl.load  = accept;
	assign store_ctrl.clear = row_last;
	assign store_ctrl.rd_en = (state_q == ST_RD);

	nlbe_index_store #(
		.NEIGHBOUR_COUNT (NEIGHBOUR_COUNT),
		.INDEX_WIDTH     (EW)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (store_ctrl),
		.wr_index  (neighbour_index[EW-1:0]),
		.rd_addr   (ent_q[AW-1:0]),
		.rd_data   (buf_rdata),
		.count     (entry_count),
		.min_index (run_min),
		.max_index (run_max),
		.dropped   (dropped)
	);

	assign sub_a     = (state_q == ST_SPAN) ? run_max : buf_rdata;
	assign diff      = sub_a - run_min;
	assign diff_byte = diff >> SW;
	assign span_cap  = (diff_byte >= EW'(MAX_ROW_BYTES));

	always_comb begin
		bm_we    = 1'b0;
		bm_waddr = pos_q;
		bm_wdata = '0;
		bm_re    = 1'b0;
		bm_raddr = pos_q;
		unique case (state_q)
			ST_CLEAR: begin
				bm_we = 1'b1;
			end
			ST_SUB: begin
				bm_re    = 1'b1;
				bm_raddr = diff_byte[BW-1:0];
			end
			ST_WR: begin
				bm_we    = hit_q;
				bm_waddr = waddr_q;
				bm_wdata = bm_rdata_q | (BITS_PER_BYTE'(1) << bit_q);
			end
			ST_EMIT: begin
				bm_re = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (bm_we) begin
			bm_mem[bm_waddr] <= bm_wdata;
		end
		if (bm_re) begin
			bm_rdata_q <= bm_mem[bm_raddr];
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ent_q   <= '0;
			pos_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && last_neighbour) begin
						state_q <= ST_SPAN;
					end
				end
				ST_SPAN: begin
					pos_q   <= '0;
					state_q <= ST_CLEAR;
				end
				ST_CLEAR: begin
					if (pos_last) begin
						ent_q   <= '0;
						state_q <= ST_RD;
					end else begin
						pos_q <= pos_q + BW'(1);
					end
				end
				ST_RD: begin
					state_q <= ST_SUB;
				end
				ST_SUB: begin
					state_q <= ST_WR;
				end
				ST_WR: begin
					if (ent_last) begin
						pos_q   <= '0;
						state_q <= ST_EMIT;
					end else begin
						ent_q   <= ent_q + CW'(1);
						state_q <= ST_RD;
					end
				end
				ST_EMIT: begin
					if (pos_last) begin
						state_q <= ST_IDLE;
					end else begin
						pos_q <= pos_q + BW'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Row-wide values are latched in the span step so that the next row can
	// start loading while the final byte is still on the result ports.
	always_ff @(posedge clk) begin
		if (state_q == ST_SPAN) begin
			offset_q <= PORT_INDEX_W'(run_min);
			ovf_q    <= dropped | span_cap;
			nbytes_q <= span_cap ? ROW_BYTES_W'(MAX_ROW_BYTES)
			                     : ROW_BYTES_W'(diff_byte) + ROW_BYTES_W'(1);
		end
		if (state_q == ST_SUB) begin
			hit_q   <= (diff_byte < EW'(nbytes_q));
			waddr_q <= diff_byte[BW-1:0];
			bit_q   <= diff[SW-1:0];
		end
		if (state_q == ST_EMIT) begin
			pos_s1 <= pos_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s1 <= 1'b0;
			end_s1  <= 1'b0;
		end else begin
			emit_s1 <= (state_q == ST_EMIT);
			end_s1  <= row_last;
		end
	end

	assign result_strobe = emit_s1;
	assign row_offset    = offset_q;
	assign row_length    = nbytes_q;
	assign byte_position = BYTE_POS_W'(pos_s1);
	assign bitmap_byte   = bm_rdata_q;
	assign row_end       = end_s1;
	assign overflow      = ovf_q;

	`NLBE_ASSERT(a_strobe_from_emit, clk, arst_n, result_strobe |-> $past(state_q == ST_EMIT), "result strobe without an emit cycle")
	`NLBE_ASSERT(a_row_end_strobed, clk, arst_n, row_end |-> result_strobe, "row end outside a result")
	`NLBE_ASSERT(a_pos_in_row, clk, arst_n, result_strobe |-> (ROW_BYTES_W'(byte_position) < row_length), "byte position beyond row length")
	`NLBE_ASSERT(a_last_starts_row, clk, arst_n, (start && !busy && last_neighbour) |=> (state_q == ST_SPAN), "marked request did not close the row")
	`NLBE_ASSERT_NEVER(a_count_bound, clk, arst_n, entry_count > CW'(NEIGHBOUR_COUNT), "entry count above buffer depth")

endmodule
